// ===== sv/repeating_timer_pool_core_assert.svh =====
// assertion macros shared by the timer pool modules
`ifndef REPEATING_TIMER_POOL_CORE_ASSERT_SVH
`define REPEATING_TIMER_POOL_CORE_ASSERT_SVH

// same-cycle implication
`define RTP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer pool assertion failed");

// next-cycle implication
`define RTP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer pool assertion failed");

`endif

// ===== sv/rtp_pkg.sv =====
`default_nettype none
package rtp_pkg;

   localparam int MODE_W   = 2;
   localparam int ID_W     = 4;
   localparam int PERIOD_W = 32;
   localparam int REPEAT_W = 8;
   localparam int MASK_W   = 8;

   localparam logic [REPEAT_W-1:0] REPEAT_FOREVER = 8'hFF;
   localparam logic [REPEAT_W-1:0] REPEAT_MAX     = 8'hFF;

   typedef enum logic [MODE_W-1:0] {
      MODE_CREATE = 2'd0,
      MODE_CANCEL = 2'd1,
      MODE_CHECK  = 2'd2,
      MODE_TICK   = 2'd3
   } mode_type;

   // classified request as it sits in the queue
   typedef struct packed {
      mode_type              mode;
      logic                  id_ok;
      logic [ID_W-1:0]       slot;
      logic [PERIOD_W-1:0]   period;
      logic [REPEAT_W-1:0]   repeats;
      logic                  callback;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } push_type;

   typedef struct packed {
      logic    not_empty;
      cmd_type cmd;
   } head_type;

endpackage
`default_nettype wire

// ===== sv/rtp_front.sv =====
`default_nettype none
module rtp_front
   import rtp_pkg::*;
#(
   parameter int NUM_SLOTS = 8
) (
   input  wire logic                start,
   input  wire logic                queue_full,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [ID_W-1:0]     req_timer_id,
   input  wire logic [PERIOD_W-1:0] req_period_ticks,
   input  wire logic [REPEAT_W-1:0] req_repeat_total,
   input  wire logic                req_has_callback,
   output push_type                 push_out
);

   always_comb begin
      push_out.push         = start && !queue_full;
      push_out.cmd.mode     = mode_type'(req_mode);
      push_out.cmd.id_ok    = {1'b0, req_timer_id} inside
                              {[(ID_W+1)'(1) : (ID_W+1)'(NUM_SLOTS)]};
      push_out.cmd.slot     = req_timer_id - ID_W'(1);
      push_out.cmd.period   = req_period_ticks;
      // zero repeats counts as one firing
      push_out.cmd.repeats  = (req_repeat_total == '0) ? REPEAT_W'(1) : req_repeat_total;
      push_out.cmd.callback = req_has_callback;
   end

endmodule
`default_nettype wire

// ===== sv/rtp_queue.sv =====
`default_nettype none
module rtp_queue
   import rtp_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push_in,
   input  wire logic     pop,
   output head_type      head,
   output logic          full
);
`include "repeating_timer_pool_core_assert.svh"

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push_in.push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      case ({push_in.push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         entry_ff[wr_ptr_ff] <= push_in.cmd;
      end
   end

   assign head.not_empty = (count_ff != '0);
   assign head.cmd       = entry_ff[rd_ptr_ff];
   assign full           = (count_ff == CNT_W'(DEPTH));

   `RTP_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `RTP_ASSERT_IMPL(a_no_push_full, clock, reset, push_in.push, count_ff != CNT_W'(DEPTH))

endmodule
`default_nettype wire

// ===== sv/rtp_back.sv =====
`default_nettype none
module rtp_back
   import rtp_pkg::*;
#(
   parameter int NUM_SLOTS = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire head_type            head,
   output logic                     pop,
   output logic                     rsp_valid,
   output logic                     rsp_success,
   output logic [ID_W-1:0]          rsp_assigned_id,
   output logic [MASK_W-1:0]        rsp_fired_mask
);
`include "repeating_timer_pool_core_assert.svh"

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_TICK = 2'b10
   } back_state_type;

   back_state_type       state_ff, state_in;
   logic [SLOT_W-1:0]    tick_idx_ff, tick_idx_in;
   logic [MASK_W-1:0]    mask_ff, mask_in, mask_next;

   logic [NUM_SLOTS-1:0] active_ff, active_in;
   logic [NUM_SLOTS-1:0] pending_ff, pending_in;
   logic [NUM_SLOTS-1:0] callback_ff, callback_in;

   logic [PERIOD_W-1:0]  count_ff  [NUM_SLOTS];
   logic [PERIOD_W-1:0]  period_ff [NUM_SLOTS];
   logic [REPEAT_W-1:0]  target_ff [NUM_SLOTS];
   logic [REPEAT_W-1:0]  done_ff   [NUM_SLOTS];

   logic                 wr_en;
   logic [SLOT_W-1:0]    wr_idx;
   logic [PERIOD_W-1:0]  count_in, period_in;
   logic [REPEAT_W-1:0]  target_in, done_in;

   logic [PERIOD_W-1:0]  cur_count, cur_period;
   logic [REPEAT_W-1:0]  cur_target, cur_done, done_sat;
   logic                 fire;

   logic [NUM_SLOTS-1:0] free_vec, free_low;
   logic [SLOT_W-1:0]    free_idx;
   logic                 has_free;
   logic [SLOT_W-1:0]    slot;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 success_ff, success_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [MASK_W-1:0]    fired_ff, fired_in;

   // lowest free slot: isolate lowest set bit, then encode
   always_comb begin
      free_vec = ~active_ff;
      free_low = free_vec & (~free_vec + NUM_SLOTS'(1));
      has_free = |free_vec;
      free_idx = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (free_low[i]) begin
            free_idx = free_idx | SLOT_W'(i);
         end
      end
   end

   assign slot       = head.cmd.slot[SLOT_W-1:0];
   assign cur_count  = count_ff[tick_idx_ff];
   assign cur_period = period_ff[tick_idx_ff];
   assign cur_target = target_ff[tick_idx_ff];
   assign cur_done   = done_ff[tick_idx_ff];

   always_comb begin
      state_in     = state_ff;
      tick_idx_in  = tick_idx_ff;
      mask_in      = mask_ff;
      mask_next    = mask_ff;
      active_in    = active_ff;
      pending_in   = pending_ff;
      callback_in  = callback_ff;
      wr_en        = 1'b0;
      wr_idx       = tick_idx_ff;
      count_in     = cur_count;
      period_in    = cur_period;
      target_in    = cur_target;
      done_in      = cur_done;
      done_sat     = cur_done;
      fire         = 1'b0;
      pop          = 1'b0;
      rsp_valid_in = 1'b0;
      success_in   = 1'b0;
      id_in        = '0;
      fired_in     = '0;

      case (state_ff)
         S_IDLE: begin
            if (head.not_empty) begin
               pop = 1'b1;
               case (head.cmd.mode)
                  MODE_CREATE: begin
                     rsp_valid_in = 1'b1;
                     if (has_free) begin
                        active_in[free_idx]   = 1'b1;
                        pending_in[free_idx]  = 1'b0;
                        callback_in[free_idx] = head.cmd.callback;
                        wr_en      = 1'b1;
                        wr_idx     = free_idx;
                        count_in   = '0;
                        period_in  = head.cmd.period;
                        target_in  = head.cmd.repeats;
                        done_in    = '0;
                        success_in = 1'b1;
                        // id sixteen does not fit and reads as zero
                        id_in = ID_W'({1'b0, free_idx} + (SLOT_W+1)'(1));
                     end
                  end
                  MODE_CANCEL: begin
                     rsp_valid_in = 1'b1;
                     if (head.cmd.id_ok) begin
                        active_in[slot]  = 1'b0;
                        pending_in[slot] = 1'b0;
                     end
                  end
                  MODE_CHECK: begin
                     rsp_valid_in = 1'b1;
                     if (head.cmd.id_ok && pending_ff[slot]) begin
                        active_in[slot]  = 1'b0;
                        pending_in[slot] = 1'b0;
                        success_in       = 1'b1;
                     end
                  end
                  MODE_TICK: begin
                     state_in    = S_TICK;
                     tick_idx_in = '0;
                     mask_in     = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_TICK: begin
            if (active_ff[tick_idx_ff]) begin
               wr_en = 1'b1;
               if (cur_count != cur_period) begin
                  count_in = cur_count + PERIOD_W'(1);
               end else begin
                  count_in = '0;
                  if (cur_target == REPEAT_FOREVER) begin
                     fire = 1'b1;
                  end else begin
                     done_sat = (cur_done == REPEAT_MAX) ? cur_done
                                                         : cur_done + REPEAT_W'(1);
                     done_in  = done_sat;
                     if (done_sat <= cur_target) begin
                        fire = 1'b1;
                     end else if (callback_ff[tick_idx_ff]) begin
                        // auto-free a callback timer after its last firing
                        active_in[tick_idx_ff]  = 1'b0;
                        pending_in[tick_idx_ff] = 1'b0;
                     end
                  end
               end
               if (fire) begin
                  pending_in[tick_idx_ff] = 1'b1;
                  if (callback_ff[tick_idx_ff] && (int'(tick_idx_ff) < MASK_W)) begin
                     mask_next = mask_ff | (MASK_W'(1) << tick_idx_ff);
                  end
               end
            end
            mask_in = mask_next;
            if (tick_idx_ff == SLOT_W'(NUM_SLOTS - 1)) begin
               rsp_valid_in = 1'b1;
               fired_in     = mask_next;
               state_in     = S_IDLE;
            end else begin
               tick_idx_in = tick_idx_ff + SLOT_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tick_idx_ff  <= '0;
         active_ff    <= '0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_idx_ff  <= tick_idx_in;
         active_ff    <= active_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff     <= mask_in;
      callback_ff <= callback_in;
      success_ff  <= success_in;
      id_ff       <= id_in;
      fired_ff    <= fired_in;
      if (wr_en) begin
         count_ff[wr_idx]  <= count_in;
         period_ff[wr_idx] <= period_in;
         target_ff[wr_idx] <= target_in;
         done_ff[wr_idx]   <= done_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_success     = success_ff;
   assign rsp_assigned_id = id_ff;
   assign rsp_fired_mask  = fired_ff;

   `RTP_ASSERT_IMPL(a_pending_only_active, clock, reset, 1'b1, (pending_ff & ~active_ff) == '0)
   `RTP_ASSERT_NEXT(a_cmd_result, clock, reset, pop && (head.cmd.mode != MODE_TICK), rsp_valid_ff)
   `RTP_ASSERT_IMPL(a_tick_quiet, clock, reset, state_ff == S_TICK, !rsp_valid_ff)

endmodule
`default_nettype wire

// ===== sv/repeating_timer_pool_core.sv =====
`default_nettype none
// Pool of NUM_SLOTS repeating timers. A request is taken when start is high and busy is low;
// busy rises only when the QUEUE_DEPTH-entry request queue (two by default) is full. Create,
// cancel and check pass the queue and the registered response stage; they sustain one request
// per cycle while no tick holds the back end. A tick walks the slot state one slot per cycle
// through the shared count/compare unit and registers its response at the last slot. Every request
// gives exactly one response, in request order, shown for one cycle with rsp_valid; the receiver
// cannot stall, so a response must be captured in the cycle it appears.
module repeating_timer_pool_core
   import rtp_pkg::*;
#(
   parameter int NUM_SLOTS   = 8,
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [ID_W-1:0]     req_timer_id,
   input  wire logic [PERIOD_W-1:0] req_period_ticks,
   input  wire logic [REPEAT_W-1:0] req_repeat_total,
   input  wire logic                req_has_callback,
   output logic                     rsp_valid,
   output logic                     rsp_success,
   output logic [ID_W-1:0]          rsp_assigned_id,
   output logic [MASK_W-1:0]        rsp_fired_mask
);

   push_type push;
   head_type head;
   logic     pop;
   logic     full;

   assign busy = full;

   rtp_front #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_front (
      .start            (start),
      .queue_full       (full),
      .req_mode         (req_mode),
      .req_timer_id     (req_timer_id),
      .req_period_ticks (req_period_ticks),
      .req_repeat_total (req_repeat_total),
      .req_has_callback (req_has_callback),
      .push_out         (push)
   );

   rtp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .head    (head),
      .full    (full)
   );

   rtp_back #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_success     (rsp_success),
      .rsp_assigned_id (rsp_assigned_id),
      .rsp_fired_mask  (rsp_fired_mask)
   );

endmodule
`default_nettype wire
